>>> hdl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, constants and the CRC-32 table function for the model
// container checker.
// ----------------------------------------------------------------------------
package mcc_pkg;

    // header layout, byte positions where each field ends
    localparam int HEADER_BYTES  = 48;
    localparam int MAGIC_END     = 8;
    localparam int FORMAT_END    = 16;
    localparam int MAJOR_END     = 20;
    localparam int MINOR_END     = 24;
    localparam int PATCH_END     = 28;
    localparam int CRC_END       = 32;
    localparam int SYS_SIZE_END  = 40;
    localparam int USER_SIZE_END = 48;

    // reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    // configuration registers
    localparam int CFG_INDEX_BITS = 2;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAGIC  = 2'd0,
        CFG_FORMAT = 2'd1,
        CFG_MAJOR  = 2'd2
    } cfg_index_t;

    localparam logic [63:0] MAGIC_RESET  = 64'd7671145711000711936;
    localparam logic [63:0] FORMAT_RESET = 64'd1;
    localparam logic [31:0] MAJOR_RESET  = 32'd1;

    // result status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_SHORT     = 3'd1,
        STAT_MAGIC     = 3'd2,
        STAT_FORMAT    = 3'd3,
        STAT_MAJOR     = 3'd4,
        STAT_LENGTH    = 3'd5,
        STAT_CRC       = 3'd6
    } status_t;

    // frame snapshot taken on the final byte
    typedef struct packed {
        logic [63:0] magic;
        logic [63:0] format;
        logic [31:0] major;
        logic [31:0] minor;
        logic [31:0] patch;
        logic [31:0] stored_crc;
        logic [31:0] computed_crc;
        logic [63:0] sys_size;
        logic [63:0] user_size;
        logic        too_short;
        logic        count_sat;
    } snap_t;

    // one entry of the byte-wise CRC table
    function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
        logic [31:0] c;
        c = {24'd0, idx};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/mcc_capture.sv
// ----------------------------------------------------------------------------
// mcc_capture
// Per-byte frame state: header field capture, running CRC and saturating
// byte counter. Loads a snapshot register on the final byte of each frame.
// ----------------------------------------------------------------------------
module mcc_capture #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_last_byte,
    output logic                   snap_valid,
    input  logic                   snap_ready,
    output mcc_pkg::snap_t         snap,
    output logic [LENGTH_BITS-1:0] snap_avail
);
    import mcc_pkg::*;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [31:0]            crc_reg, crc_next;
    logic [63:0]            magic_reg, magic_next;
    logic [63:0]            format_reg, format_next;
    logic [31:0]            major_reg, major_next;
    logic [31:0]            minor_reg, minor_next;
    logic [31:0]            patch_reg, patch_next;
    logic [31:0]            scrc_reg, scrc_next;
    logic [63:0]            sys_reg, sys_next;
    logic [63:0]            user_reg, user_next;

    logic                   snap_valid_reg;
    snap_t                  snap_reg, snap_next;
    logic [LENGTH_BITS-1:0] avail_reg;
    logic                   accept;

    assign s_ready    = !snap_valid_reg || snap_ready;
    assign accept     = s_valid && s_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
    assign snap_avail = avail_reg;

    // field capture, crc and counter update for the current byte
    always_comb begin
        magic_next  = magic_reg;
        format_next = format_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        patch_next  = patch_reg;
        scrc_next   = scrc_reg;
        sys_next    = sys_reg;
        user_next   = user_reg;

        if (count_reg < LENGTH_BITS'(MAGIC_END)) begin
            magic_next = {magic_reg[55:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(FORMAT_END)) begin
            format_next = {format_reg[55:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(MAJOR_END)) begin
            major_next = {major_reg[23:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(MINOR_END)) begin
            minor_next = {minor_reg[23:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(PATCH_END)) begin
            patch_next = {patch_reg[23:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(CRC_END)) begin
            scrc_next = {scrc_reg[23:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(SYS_SIZE_END)) begin
            sys_next = {sys_reg[55:0], s_data_byte};
        end else if (count_reg < LENGTH_BITS'(USER_SIZE_END)) begin
            user_next = {user_reg[55:0], s_data_byte};
        end

        // stored crc bytes are left out of the running crc
        if (count_reg < LENGTH_BITS'(PATCH_END) || count_reg >= LENGTH_BITS'(CRC_END)) begin
            crc_next = (crc_reg >> 8) ^ crc_table_entry(crc_reg[7:0] ^ s_data_byte);
        end else begin
            crc_next = crc_reg;
        end

        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + LENGTH_BITS'(1);
        end else begin
            count_next = count_reg;
        end
    end

    // snapshot contents for the final byte
    always_comb begin
        snap_next.magic        = magic_next;
        snap_next.format       = format_next;
        snap_next.major        = major_next;
        snap_next.minor        = minor_next;
        snap_next.patch        = patch_next;
        snap_next.stored_crc   = scrc_next;
        snap_next.computed_crc = crc_next ^ CRC_ONES;
        snap_next.sys_size     = sys_next;
        snap_next.user_size    = user_next;
        snap_next.too_short    = count_next < LENGTH_BITS'(HEADER_BYTES);
        snap_next.count_sat    = count_next == COUNT_MAX;
    end

    // frame state, cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            crc_reg    <= CRC_ONES;
            magic_reg  <= '0;
            format_reg <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            patch_reg  <= '0;
            scrc_reg   <= '0;
            sys_reg    <= '0;
            user_reg   <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                count_reg  <= '0;
                crc_reg    <= CRC_ONES;
                magic_reg  <= '0;
                format_reg <= '0;
                major_reg  <= '0;
                minor_reg  <= '0;
                patch_reg  <= '0;
                scrc_reg   <= '0;
                sys_reg    <= '0;
                user_reg   <= '0;
            end else begin
                count_reg  <= count_next;
                crc_reg    <= crc_next;
                magic_reg  <= magic_next;
                format_reg <= format_next;
                major_reg  <= major_next;
                minor_reg  <= minor_next;
                patch_reg  <= patch_next;
                scrc_reg   <= scrc_next;
                sys_reg    <= sys_next;
                user_reg   <= user_next;
            end
        end
    end

    // snapshot valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_ready) begin
            snap_valid_reg <= 1'b0;
        end
    end

    // snapshot payload
    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            snap_reg  <= snap_next;
            avail_reg <= count_next - LENGTH_BITS'(HEADER_BYTES);
        end
    end

endmodule

>>> hdl/mcc_check.sv
// ----------------------------------------------------------------------------
// mcc_check
// Header checks in priority order on a frame snapshot, and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module mcc_check #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   snap_valid,
    output logic                   snap_ready,
    input  mcc_pkg::snap_t         snap,
    input  logic [LENGTH_BITS-1:0] snap_avail,
    input  logic [63:0]            exp_magic,
    input  logic [63:0]            exp_format,
    input  logic [31:0]            exp_major,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [31:0]            m_computed_crc,
    output logic [31:0]            m_stored_crc,
    output logic [63:0]            m_system_section_size,
    output logic [63:0]            m_user_section_size,
    output logic [31:0]            m_minor_version,
    output logic [31:0]            m_patch_version
);
    import mcc_pkg::*;

    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [31:0] ccrc_reg, scrc_reg, minor_reg, patch_reg;
    logic [63:0] sys_reg, user_reg;
    logic [64:0] size_sum;
    logic        length_bad;
    logic        load;

    assign snap_ready = !out_valid_reg || m_ready;
    assign load       = snap_valid && snap_ready;

    // sizes must add up to the bytes after the header, no wrap-around
    assign size_sum   = {1'b0, snap.sys_size} + {1'b0, snap.user_size};
    assign length_bad = snap.count_sat || (size_sum != 65'(snap_avail));

    // first failing check wins
    always_comb begin
        if (snap.too_short) begin
            status_next = STAT_SHORT;
        end else if (snap.magic != exp_magic) begin
            status_next = STAT_MAGIC;
        end else if (snap.format != exp_format) begin
            status_next = STAT_FORMAT;
        end else if (snap.major != exp_major) begin
            status_next = STAT_MAJOR;
        end else if (length_bad) begin
            status_next = STAT_LENGTH;
        end else if (snap.computed_crc != snap.stored_crc) begin
            status_next = STAT_CRC;
        end else begin
            status_next = STAT_OK;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_next;
            ccrc_reg   <= snap.computed_crc;
            scrc_reg   <= snap.stored_crc;
            sys_reg    <= snap.sys_size;
            user_reg   <= snap.user_size;
            minor_reg  <= snap.minor;
            patch_reg  <= snap.patch;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_status              = status_reg;
    assign m_computed_crc        = ccrc_reg;
    assign m_stored_crc          = scrc_reg;
    assign m_system_section_size = sys_reg;
    assign m_user_section_size   = user_reg;
    assign m_minor_version       = minor_reg;
    assign m_patch_version       = patch_reg;

endmodule

>>> hdl/model_container_checker_unit.sv
// ----------------------------------------------------------------------------
// model_container_checker_unit
// Byte-stream checker for a saved model container: header capture, CRC-32,
// length and version checks, one result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one file byte per transfer, s_last_byte marks the final byte.
//   m_ channel: one result transfer per frame, status plus captured fields.
//   cfg channel: writes expected magic (0), format version (1) and major
//   version (2); cfg_ready is always high, other indexes are dropped.
//   Configure only while no frame is in flight.
// Throughput: one byte per cycle while s_ready is high; the CRC advances a full
//   byte per cycle through a 256-entry table.
// Result path: the frame snapshot register loads on the final byte transfer,
//   then the result register that drives m_valid and the m_ channel loads
//   from the snapshot register.
// Stalls: while m_ready is low the result register holds one result and the
//   snapshot register one more; once both are full s_ready drops and no
//   byte is taken until the result transfers.
// Reset: frame state cleared, CRC set to all ones, config registers loaded
//   with their defaults, no result pending.
// ----------------------------------------------------------------------------
module model_container_checker_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic [31:0]                         m_computed_crc,
    output logic [31:0]                         m_stored_crc,
    output logic [63:0]                         m_system_section_size,
    output logic [63:0]                         m_user_section_size,
    output logic [31:0]                         m_minor_version,
    output logic [31:0]                         m_patch_version,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [63:0]                         cfg_data
);
    import mcc_pkg::*;

    logic [63:0]            magic_cfg_reg;
    logic [63:0]            format_cfg_reg;
    logic [31:0]            major_cfg_reg;
    logic                   snap_valid;
    logic                   snap_ready;
    snap_t                  snap;
    logic [LENGTH_BITS-1:0] snap_avail;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_cfg_reg  <= MAGIC_RESET;
            format_cfg_reg <= FORMAT_RESET;
            major_cfg_reg  <= MAJOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAGIC:  magic_cfg_reg  <= cfg_data;
                CFG_FORMAT: format_cfg_reg <= cfg_data;
                CFG_MAJOR:  major_cfg_reg  <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // byte capture and running crc
    mcc_capture #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap),
        .snap_avail  (snap_avail)
    );

    // checks and result register
    mcc_check #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .snap_valid            (snap_valid),
        .snap_ready            (snap_ready),
        .snap                  (snap),
        .snap_avail            (snap_avail),
        .exp_magic             (magic_cfg_reg),
        .exp_format            (format_cfg_reg),
        .exp_major             (major_cfg_reg),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_computed_crc        (m_computed_crc),
        .m_stored_crc          (m_stored_crc),
        .m_system_section_size (m_system_section_size),
        .m_user_section_size   (m_user_section_size),
        .m_minor_version       (m_minor_version),
        .m_patch_version       (m_patch_version)
    );

endmodule

>>> sim/model_container_checker_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// model_container_checker_unit_test
// Self-checking bench for the model container checker. Container frames are
// streamed in one byte per transfer. A predictor follows the header capture,
// the CRC-32 and the status checks of every frame. Each result transfer is
// compared field by field with the oldest prediction. A directed table comes
// first, then random frames under three register settings and idling mixes.
// ----------------------------------------------------------------------------
module model_container_checker_unit_test;
    import mcc_pkg::*;

    // narrowest supported byte counter
    localparam int          COUNT_BITS  = 16;
    localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          FILL_RANDOM = -1;
    localparam int          NO_TYPED    = -1;
    localparam int          SHOWN_FAULTS = 10;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [63:0] magic;
        logic [63:0] format;
        logic [31:0] major;
        logic [31:0] minor;
        logic [31:0] patch;
        logic [31:0] crc;
        logic [63:0] sys_size;
        logic [63:0] user_size;
    } header_t;

    typedef struct {
        header_t hdr;
        int      len;
        bit      crc_good;
        int      fill;
        int      typed;
    } frame_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] computed_crc;
        logic [31:0] stored_crc;
        logic [63:0] sys_size;
        logic [63:0] user_size;
        logic [31:0] minor;
        logic [31:0] patch;
    } report_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_data_byte = 8'd0;
    logic                      s_last_byte = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [2:0]                m_status;
    logic [31:0]               m_computed_crc;
    logic [31:0]               m_stored_crc;
    logic [63:0]               m_system_section_size;
    logic [63:0]               m_user_section_size;
    logic [31:0]               m_minor_version;
    logic [31:0]               m_patch_version;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [63:0]               cfg_data = '0;

    // register copies and frame state of the predictor
    logic [63:0] want_magic;
    logic [63:0] want_format;
    logic [31:0] want_major;
    logic [63:0] seen_count;
    logic [31:0] seen_crc_run;
    logic [63:0] seen_magic;
    logic [63:0] seen_format;
    logic [31:0] seen_major;
    logic [31:0] seen_minor;
    logic [31:0] seen_patch;
    logic [31:0] seen_stored;
    logic [63:0] seen_sys;
    logic [63:0] seen_user;

    report_t due_reports[$];
    int      typed_status[$];
    int      faults = 0;
    int      quiet = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    model_container_checker_unit #(
        .LENGTH_BITS(COUNT_BITS)
    ) u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_data_byte           (s_data_byte),
        .s_last_byte           (s_last_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_computed_crc        (m_computed_crc),
        .m_stored_crc          (m_stored_crc),
        .m_system_section_size (m_system_section_size),
        .m_user_section_size   (m_user_section_size),
        .m_minor_version       (m_minor_version),
        .m_patch_version       (m_patch_version),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    // reflected crc-32, one byte, bit by bit
    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        return x;
    endfunction

    function automatic void clear_frame_model();
        seen_count   = '0;
        seen_crc_run = CRC_ONES;
        seen_magic   = '0;
        seen_format  = '0;
        seen_major   = '0;
        seen_minor   = '0;
        seen_patch   = '0;
        seen_stored  = '0;
        seen_sys     = '0;
        seen_user    = '0;
    endfunction

    // follow one accepted byte, return 1 with the frame report on the final byte
    function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                       output report_t r);
        logic [63:0] pos;
        logic [63:0] avail;
        status_t     stat;
        int          typed;
        pos = seen_count;
        r = '0;
        if (pos < MAGIC_END) seen_magic = {seen_magic[55:0], b};
        else if (pos < FORMAT_END) seen_format = {seen_format[55:0], b};
        else if (pos < MAJOR_END) seen_major = {seen_major[23:0], b};
        else if (pos < MINOR_END) seen_minor = {seen_minor[23:0], b};
        else if (pos < PATCH_END) seen_patch = {seen_patch[23:0], b};
        else if (pos < CRC_END) seen_stored = {seen_stored[23:0], b};
        else if (pos < SYS_SIZE_END) seen_sys = {seen_sys[55:0], b};
        else if (pos < USER_SIZE_END) seen_user = {seen_user[55:0], b};
        // stored crc bytes stay out of the running crc
        if (pos < PATCH_END || pos >= CRC_END) seen_crc_run = crc_next(seen_crc_run, b);
        if (seen_count < COUNT_MAX) seen_count = seen_count + 64'd1;
        if (!last) return 1'b0;

        // first failing check wins
        avail = seen_count - HEADER_BYTES;
        if (seen_count < HEADER_BYTES) stat = STAT_SHORT;
        else if (seen_magic != want_magic) stat = STAT_MAGIC;
        else if (seen_format != want_format) stat = STAT_FORMAT;
        else if (seen_major != want_major) stat = STAT_MAJOR;
        else if (seen_count == COUNT_MAX || seen_sys > avail ||
                 seen_user != avail - seen_sys) stat = STAT_LENGTH;
        else if (~seen_crc_run != seen_stored) stat = STAT_CRC;
        else stat = STAT_OK;

        // table rows with a status written in take that one
        typed = typed_status.pop_front();
        if (typed != NO_TYPED) stat = status_t'(typed);

        r.status       = stat;
        r.computed_crc = ~seen_crc_run;
        r.stored_crc   = seen_stored;
        r.sys_size     = seen_sys;
        r.user_size    = seen_user;
        r.minor        = seen_minor;
        r.patch        = seen_patch;
        clear_frame_model();
        return 1'b1;
    endfunction

    function automatic void count_fault(input string msg);
        faults++;
        if (faults <= SHOWN_FAULTS) $display("%s", msg);
    endfunction

    // receiver: ready dropped at random, cycle by cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // predictor, result compare, register tracking and watchdog
    always @(posedge aclk) begin : scoreboard
        report_t want_r;
        report_t got_r;
        bit      moved;
        if (!aresetn) begin
            want_magic  = MAGIC_RESET;
            want_format = FORMAT_RESET;
            want_major  = MAJOR_RESET;
            clear_frame_model();
        end else begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                moved = 1'b1;
                if (absorb_byte(s_data_byte, s_last_byte, want_r)) due_reports.push_back(want_r);
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                got_r.status       = status_t'(m_status);
                got_r.computed_crc = m_computed_crc;
                got_r.stored_crc   = m_stored_crc;
                got_r.sys_size     = m_system_section_size;
                got_r.user_size    = m_user_section_size;
                got_r.minor        = m_minor_version;
                got_r.patch        = m_patch_version;
                if (due_reports.size() == 0) begin
                    count_fault($sformatf("unexpected result transfer, status %0d", m_status));
                end else begin
                    want_r = due_reports.pop_front();
                    if (got_r !== want_r) begin
                        count_fault($sformatf({"mismatch (expected/actual): status %0d/%0d",
                            " crc %h/%h stored %h/%h sys %h/%h user %h/%h",
                            " minor %h/%h patch %h/%h"},
                            want_r.status, got_r.status,
                            want_r.computed_crc, got_r.computed_crc,
                            want_r.stored_crc, got_r.stored_crc,
                            want_r.sys_size, got_r.sys_size,
                            want_r.user_size, got_r.user_size,
                            want_r.minor, got_r.minor, want_r.patch, got_r.patch));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_MAGIC:  want_magic  = cfg_data;
                    CFG_FORMAT: want_format = cfg_data;
                    CFG_MAJOR:  want_major  = cfg_data[31:0];
                    default: ;
                endcase
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("model_container_checker_unit_test: done, errors");
                $finish;
            end
        end
    end

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // lay out header and payload, patch in the crc if asked, stream it
    task automatic send_frame(input frame_t f);
        logic [7:0]   fb[$];
        logic [383:0] flat;
        logic [31:0]  c;
        flat = f.hdr;
        for (int i = 0; i < f.len; i++) begin
            if (i < HEADER_BYTES) fb.push_back(flat[383 - 8*i -: 8]);
            else if (f.fill == FILL_RANDOM) fb.push_back(8'($urandom));
            else fb.push_back(8'(f.fill));
        end
        if (f.crc_good && f.len >= HEADER_BYTES) begin
            c = CRC_ONES;
            for (int i = 0; i < f.len; i++) begin
                if (i < PATCH_END || i >= CRC_END) c = crc_next(c, fb[i]);
            end
            c = ~c;
            for (int i = 0; i < 4; i++) fb[PATCH_END + i] = c[31 - 8*i -: 8];
        end
        typed_status.push_back(f.typed);
        for (int i = 0; i < f.len; i++) send_byte(fb[i], i == f.len - 1);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // all three registers, plus a write to the unused index that must not stick
    task automatic load_config(input logic [63:0] magic, input logic [63:0] format,
                               input logic [63:0] major);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_FORMAT, format);
        write_reg(CFG_MAJOR, major);
        write_reg(CFG_SPARE, {$urandom, $urandom});
    endtask

    // header that passes the version checks under the current registers
    function automatic header_t fit_header(input logic [63:0] sys, input logic [63:0] user);
        header_t h;
        h.magic     = want_magic;
        h.format    = want_format;
        h.major     = want_major;
        h.minor     = $urandom;
        h.patch     = $urandom;
        h.crc       = '0;
        h.sys_size  = sys;
        h.user_size = user;
        return h;
    endfunction

    // mostly well-formed frames, some with one broken field, some short or noise
    function automatic frame_t random_frame();
        frame_t       f;
        logic [383:0] noise;
        int           kind;
        int           len;
        int           sys;
        kind = $urandom_range(99);
        len = HEADER_BYTES + $urandom_range(16);
        sys = $urandom_range(len - HEADER_BYTES);
        f.hdr = fit_header(64'(sys), 64'(len - HEADER_BYTES - sys));
        f.len = len;
        f.crc_good = ($urandom_range(9) != 0);
        f.fill = FILL_RANDOM;
        f.typed = NO_TYPED;
        if (kind >= 65 && kind < 85) begin
            case ($urandom_range(3))
                0: f.hdr.magic = f.hdr.magic ^ (64'd1 << $urandom_range(63));
                1: f.hdr.format = f.hdr.format ^ (64'd1 << $urandom_range(63));
                2: f.hdr.major = f.hdr.major ^ (32'd1 << $urandom_range(31));
                default: f.hdr.user_size = f.hdr.user_size ^ (64'd1 << $urandom_range(63));
            endcase
        end else if (kind >= 85 && kind < 93) begin
            f.len = $urandom_range(HEADER_BYTES - 1, 1);
        end else if (kind >= 93) begin
            noise = '0;
            repeat (12) noise = {noise[351:0], $urandom};
            f.hdr = noise;
            f.crc_good = 1'b0;
            f.len = $urandom_range(64, 1);
        end
        return f;
    endfunction

    task automatic run_random(input int byte_goal);
        frame_t f;
        int     sent;
        int     frames;
        sent = 0;
        frames = 0;
        while (sent < byte_goal || frames < 6) begin
            f = random_frame();
            send_frame(f);
            sent += f.len;
            frames++;
        end
    endtask

    task automatic add_row(ref frame_t plan[$], input header_t h, input int len,
                           input bit crc_good, input int fill, input int typed);
        frame_t f;
        f.hdr = h;
        f.len = len;
        f.crc_good = crc_good;
        f.fill = fill;
        f.typed = typed;
        plan.push_back(f);
    endtask

    initial begin : stimulus
        frame_t  plan[$];
        header_t h;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 36;
        rx_idle_pct = 46;

        // directed frames under the reset register values
        h = '0;
        add_row(plan, h, 1, 1'b0, 8'h00, STAT_SHORT);
        h = fit_header(0, 0);
        add_row(plan, h, HEADER_BYTES - 1, 1'b1, FILL_RANDOM, STAT_SHORT);
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_OK);
        h.magic = '0;
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_MAGIC);
        h.magic = '1;
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_MAGIC);
        h = fit_header(0, 0);
        h.format = '1;
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_FORMAT);
        h = fit_header(0, 0);
        h.major = '0;
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_MAJOR);
        h.major = '1;
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_MAJOR);
        h = fit_header(1, 0);
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_LENGTH);
        h = fit_header(4, 5);
        add_row(plan, h, 58, 1'b1, FILL_RANDOM, STAT_LENGTH);
        // size sum that wraps around must still be a mismatch
        h = fit_header('1, 1);
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_LENGTH);
        h = fit_header(0, '1);
        add_row(plan, h, HEADER_BYTES, 1'b1, FILL_RANDOM, STAT_LENGTH);
        h = fit_header(12, 0);
        add_row(plan, h, 60, 1'b0, FILL_RANDOM, STAT_CRC);
        h.crc = '1;
        add_row(plan, h, 60, 1'b0, FILL_RANDOM, STAT_CRC);
        h = fit_header(10, 0);
        add_row(plan, h, 58, 1'b1, FILL_RANDOM, NO_TYPED);
        h = fit_header(30, 22);
        h.minor = '1;
        h.patch = '1;
        add_row(plan, h, 100, 1'b1, 8'hFF, NO_TYPED);
        h = fit_header(0, 52);
        h.minor = '0;
        h.patch = '0;
        add_row(plan, h, 100, 1'b1, 8'h00, NO_TYPED);
        foreach (plan[i]) send_frame(plan[i]);
        wait_idle();

        // random registers, sender idles less than receiver
        load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        run_random(290);
        wait_idle();

        // all-zero registers, idling swapped
        tx_idle_pct = 46;
        rx_idle_pct = 36;
        load_config('0, '0, '0);
        run_random(290);
        wait_idle();

        // all-ones registers, no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_config('1, '1, '1);
        run_random(290);
        wait_idle();

        if (faults == 0 && due_reports.size() == 0) begin
            $display("model_container_checker_unit_test: done, clean");
        end else begin
            $display("model_container_checker_unit_test: done, errors");
        end
        $finish;
    end

endmodule
